// ===== rtl/audio_jitter_buffer_control_assert.svh =====
// assertion macros for the jitter buffer control block
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef AUDIO_JITTER_BUFFER_CONTROL_ASSERT_SVH
`define AUDIO_JITTER_BUFFER_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
`define AJB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AJB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AJB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define AJB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ajb_pkg.sv =====
// shared widths, result codes, result struct and concealment step
// used by every module of the jitter buffer control block
package ajb_pkg;

	localparam int SEQ_W         = 16;
	localparam int TD_W          = 5;
	localparam int KIND_W        = 3;
	localparam int GAIN_W        = 4;
	localparam int SLOTS_DEF     = 32;
	localparam int MAX_NACKS_DEF = 8;

	localparam logic [TD_W-1:0]   TD_RESET  = 5'd4;
	localparam logic [GAIN_W-1:0] FULL_GAIN = 4'd8;

	localparam logic REQ_GET = 1'b1;

	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DROP  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NACK  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FRAME = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CONC  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PRE   = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  nack_seq;
		logic              silence;
		logic [GAIN_W-1:0] gain_start;
		logic [GAIN_W-1:0] gain_end;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              silence;
		logic [GAIN_W-1:0] g0;
		logic [GAIN_W-1:0] g1;
		logic [GAIN_W-1:0] fade_next;
	} conceal_t;

	function automatic conceal_t conceal_step(input logic good, input logic [GAIN_W-1:0] fade);
		conceal_t c;
		c = '0;
		if (!good || fade == '0) begin
			c.silence = 1'b1;
		end else begin
			c.g0        = fade;
			c.g1        = fade - 1'b1;
			c.fade_next = fade - 1'b1;
		end
		return c;
	endfunction

endpackage

// ===== rtl/audio_jitter_buffer_control.sv =====
// jitter buffer control top: config register, output register, sequencer; uses ajb_pkg, ajb_ctrl
// results: a drop is issued from S_DRP; a slot write passes S_DRP, S_DWP, S_MOD, S_REM, S_RD
// and S_PW, issuing nacks from S_NACK after a sequence gap (entered via S_SKIP while playing);
// a get is issued from S_GET0 while prebuffering, else via S_MOD to S_GU; one word at a time
// reset: asynchronous; then a clearing pass over every slot during which no input word is taken
module audio_jitter_buffer_control #(
	parameter int SLOTS     = ajb_pkg::SLOTS_DEF,
	parameter int MAX_NACKS = ajb_pkg::MAX_NACKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ajb_pkg::TD_W-1:0]   start_depth,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [ajb_pkg::SEQ_W-1:0]  seq_num,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ajb_pkg::KIND_W-1:0] kind,
	output logic [$clog2(SLOTS)-1:0]   slot_index,
	output logic [ajb_pkg::SEQ_W-1:0]  nack_seq,
	output logic                       silence,
	output logic [ajb_pkg::GAIN_W-1:0] gain_start,
	output logic [ajb_pkg::GAIN_W-1:0] gain_end,
	output logic                       last
);
	import ajb_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic [TD_W-1:0]  target_q;
	logic             out_valid_q;
	res_t             res_q;
	logic [IDX_W-1:0] slot_q;
	logic             idle;
	logic             in_fire;
	logic             out_free;
	logic             emit_valid;
	res_t             emit_res;
	logic [IDX_W-1:0] emit_slot;

	assign cfg_ready = 1'b1;
	assign in_stall  = !idle;
	assign in_fire   = in_valid && idle;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= start_depth;
		end
	end

	ajb_ctrl #(
		.SLOTS     (SLOTS),
		.MAX_NACKS (MAX_NACKS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.req_type     (req_type),
		.seq_num      (seq_num),
		.start_depth  (target_q),
		.out_free     (out_free),
		.idle         (idle),
		.emit_valid   (emit_valid),
		.emit_res     (emit_res),
		.emit_slot    (emit_slot)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			res_q  <= emit_res;
			slot_q <= emit_slot;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = res_q.kind;
	assign slot_index = slot_q;
	assign nack_seq   = res_q.nack_seq;
	assign silence    = res_q.silence;
	assign gain_start = res_q.gain_start;
	assign gain_end   = res_q.gain_end;
	assign last       = res_q.last;

endmodule

// ===== rtl/ajb_sub.sv =====
// shared 16-bit subtractor
// serves sequence distances and the slot remainder; uses ajb_pkg
module ajb_sub (
	input  logic [ajb_pkg::SEQ_W-1:0] a,
	input  logic [ajb_pkg::SEQ_W-1:0] b,
	output logic [ajb_pkg::SEQ_W-1:0] diff
);
	import ajb_pkg::*;

	assign diff = a - b;

endmodule

// ===== rtl/ajb_ctrl.sv =====
// sequencer, slot store and buffer state of the jitter buffer control
// uses ajb_pkg, ajb_sub and the assertion macro header
`include "audio_jitter_buffer_control_assert.svh"

module ajb_ctrl #(
	parameter int SLOTS     = ajb_pkg::SLOTS_DEF,
	parameter int MAX_NACKS = ajb_pkg::MAX_NACKS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_fire,
	input  logic                      req_type,
	input  logic [ajb_pkg::SEQ_W-1:0] seq_num,
	input  logic [ajb_pkg::TD_W-1:0]  start_depth,
	input  logic                      out_free,
	output logic                      idle,
	output logic                      emit_valid,
	output ajb_pkg::res_t             emit_res,
	output logic [$clog2(SLOTS)-1:0]  emit_slot
);
	import ajb_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int NCNT_W = $clog2(MAX_NACKS + 1);
	localparam int CMP_W  = (CNT_W > TD_W) ? CNT_W : TD_W;
	localparam int RCP_W  = SEQ_W + 1;
	localparam int PROD_W = SEQ_W + RCP_W;
	localparam int RCP_SH = SEQ_W + $clog2(SLOTS);
	localparam longint RCP_DIV = ((longint'(1) << RCP_SH) + longint'(SLOTS) - 1) / longint'(SLOTS);
	localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_DIV);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_DRP   = 12'b000000000100,
		S_DWP   = 12'b000000001000,
		S_SKIP  = 12'b000000010000,
		S_NACK  = 12'b000000100000,
		S_MOD   = 12'b000001000000,
		S_REM   = 12'b000010000000,
		S_RD    = 12'b000100000000,
		S_PW    = 12'b001000000000,
		S_GET0  = 12'b010000000000,
		S_GU    = 12'b100000000000
	} state_t;

	state_t              state_q;
	logic                req_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [SEQ_W-1:0]    rp_q;
	logic [SEQ_W-1:0]    wp_q;
	logic [SEQ_W-1:0]    miss_q;
	logic [SEQ_W-1:0]    src_q;
	logic [SEQ_W-1:0]    quo_q;
	logic                playing_q;
	logic                anchored_q;
	logic                good_q;
	logic                conc_q;
	logic                ahead_q;
	logic [GAIN_W-1:0]   fade_q;
	logic [CNT_W-1:0]    filled_q;
	logic [NCNT_W-1:0]   nack_cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    clr_q;
	logic [SEQ_W:0]      mem_q [SLOTS];
	logic [SEQ_W:0]      rd_q;

	logic [SEQ_W-1:0]    alu_a;
	logic [SEQ_W-1:0]    alu_b;
	logic [SEQ_W-1:0]    alu_diff;
	logic [PROD_W-1:0]   rcp_prod;
	logic                d_neg;
	logic                d_pos;
	logic                d_gap;
	logic                drop;
	logic                prebuf;
	logic                hit;
	logic                nack_more;
	conceal_t            cnc;
	logic [GAIN_W-1:0]   frame_g0;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_addr;
	logic [SEQ_W:0]      mem_wdata;

	ajb_sub u_sub (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff)
	);

	// slot quotient by reciprocal multiply
	assign rcp_prod = PROD_W'(src_q) * PROD_W'(RCP_M);

	always_comb begin
		case (state_q)
			S_DWP: begin
				alu_a = seq_q;
				alu_b = wp_q;
			end
			S_SKIP: begin
				alu_a = miss_q;
				alu_b = rp_q;
			end
			S_NACK: begin
				alu_a = seq_q;
				alu_b = miss_q;
			end
			S_REM: begin
				alu_a = src_q;
				alu_b = quo_q * SEQ_W'(SLOTS);
			end
			default: begin
				alu_a = seq_q;
				alu_b = rp_q;
			end
		endcase
	end

	assign d_neg     = alu_diff[SEQ_W-1];
	assign d_pos     = !d_neg && (alu_diff != '0);
	assign d_gap     = !d_neg && (alu_diff > SEQ_W'(1));
	assign drop      = (playing_q && d_neg) || (!d_neg && (alu_diff >= SEQ_W'(SLOTS)));
	assign prebuf    = !playing_q && (!anchored_q || (CMP_W'(filled_q) < CMP_W'(start_depth)));
	assign hit       = rd_q[SEQ_W] && (rd_q[SEQ_W-1:0] == rp_q);
	assign nack_more = d_pos && (nack_cnt_q != NCNT_W'(MAX_NACKS));
	assign cnc       = conceal_step(good_q, fade_q);
	assign frame_g0  = (conc_q && (fade_q < FULL_GAIN)) ? fade_q : FULL_GAIN;
	assign idle      = (state_q == S_IDLE);

	// result word for the output register
	always_comb begin
		emit_valid = 1'b0;
		emit_res   = '0;
		emit_slot  = '0;
		case (state_q)
			S_DRP: begin
				if (drop) begin
					emit_valid    = out_free;
					emit_res.kind = KIND_DROP;
					emit_res.last = 1'b1;
				end
			end
			S_NACK: begin
				if (nack_more) begin
					emit_valid        = out_free;
					emit_res.kind     = KIND_NACK;
					emit_res.nack_seq = miss_q;
				end
			end
			S_PW: begin
				emit_valid    = out_free;
				emit_res.kind = KIND_WRITE;
				emit_res.last = 1'b1;
				emit_slot     = idx_q;
			end
			S_GET0: begin
				if (prebuf) begin
					emit_valid          = out_free;
					emit_res.kind       = KIND_PRE;
					emit_res.silence    = cnc.silence;
					emit_res.gain_start = cnc.g0;
					emit_res.gain_end   = cnc.g1;
					emit_res.last       = 1'b1;
				end
			end
			S_GU: begin
				emit_valid    = out_free;
				emit_res.last = 1'b1;
				if (hit) begin
					emit_res.kind       = KIND_FRAME;
					emit_res.gain_start = frame_g0;
					emit_res.gain_end   = FULL_GAIN;
					emit_slot           = idx_q;
				end else begin
					emit_res.kind       = (filled_q == '0) ? KIND_PRE : KIND_CONC;
					emit_res.silence    = cnc.silence;
					emit_res.gain_start = cnc.g0;
					emit_res.gain_end   = cnc.g1;
				end
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = {1'b1, seq_q};
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_PW: begin
				mem_we = out_free;
			end
			S_GU: begin
				mem_we    = out_free && hit;
				mem_wdata = {1'b0, rd_q[SEQ_W-1:0]};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// slot store: valid bit over tag
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			req_q      <= 1'b0;
			seq_q      <= '0;
			rp_q       <= '0;
			wp_q       <= '0;
			miss_q     <= '0;
			src_q      <= '0;
			quo_q      <= '0;
			playing_q  <= 1'b0;
			anchored_q <= 1'b0;
			good_q     <= 1'b0;
			conc_q     <= 1'b0;
			ahead_q    <= 1'b0;
			fade_q     <= FULL_GAIN;
			filled_q   <= '0;
			nack_cnt_q <= '0;
			idx_q      <= '0;
			clr_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						req_q <= req_type;
						seq_q <= seq_num;
						if (req_type == REQ_GET) begin
							state_q <= S_GET0;
						end else begin
							if (!anchored_q) begin
								anchored_q <= 1'b1;
								playing_q  <= 1'b0;
								rp_q       <= seq_num;
								wp_q       <= seq_num;
							end
							state_q <= S_DRP;
						end
					end
				end
				S_DRP: begin
					if (!drop) begin
						state_q <= S_DWP;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DWP: begin
					ahead_q    <= d_pos;
					miss_q     <= wp_q + 1'b1;
					nack_cnt_q <= '0;
					if (d_gap) begin
						state_q <= playing_q ? S_SKIP : S_NACK;
					end else begin
						src_q   <= seq_q;
						state_q <= S_MOD;
					end
				end
				S_SKIP: begin
					// numbers behind the read counter get no nack
					if (d_neg) begin
						miss_q <= rp_q;
					end
					state_q <= S_NACK;
				end
				S_NACK: begin
					if (nack_more) begin
						if (out_free) begin
							miss_q     <= miss_q + 1'b1;
							nack_cnt_q <= nack_cnt_q + 1'b1;
						end
					end else begin
						src_q   <= seq_q;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					quo_q   <= SEQ_W'(rcp_prod >> RCP_SH);
					state_q <= S_REM;
				end
				S_REM: begin
					idx_q   <= alu_diff[IDX_W-1:0];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (req_q == REQ_GET) ? S_GU : S_PW;
				end
				S_PW: begin
					if (out_free) begin
						if (!rd_q[SEQ_W]) begin
							filled_q <= filled_q + 1'b1;
						end
						if (ahead_q) begin
							wp_q <= seq_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_GET0: begin
					if (prebuf) begin
						if (out_free) begin
							conc_q  <= 1'b1;
							fade_q  <= cnc.fade_next;
							state_q <= S_IDLE;
						end
					end else begin
						playing_q <= 1'b1;
						src_q     <= rp_q;
						state_q   <= S_MOD;
					end
				end
				S_GU: begin
					if (out_free) begin
						if (hit) begin
							filled_q <= filled_q - 1'b1;
							rp_q     <= rp_q + 1'b1;
							good_q   <= 1'b1;
							fade_q   <= FULL_GAIN;
							conc_q   <= 1'b0;
						end else if (filled_q == '0) begin
							// underrun
							playing_q  <= 1'b0;
							anchored_q <= 1'b0;
							conc_q     <= 1'b1;
							fade_q     <= cnc.fade_next;
						end else begin
							rp_q   <= rp_q + 1'b1;
							conc_q <= 1'b1;
							fade_q <= cnc.fade_next;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`AJB_ASSERT_IMP(a_emit_free, clk, arst_n, emit_valid, out_free, "result issued while output busy")
	`AJB_ASSERT_NXT(a_fire_busy, clk, arst_n, in_fire, state_q != S_IDLE, "word taken but sequencer idle")
	`AJB_ASSERT_IMP(a_play_anchor, clk, arst_n, playing_q, anchored_q, "playing without anchor")
	`AJB_ASSERT_IMP(a_nack_limit, clk, arst_n, emit_valid && emit_res.kind == KIND_NACK, nack_cnt_q < NCNT_W'(MAX_NACKS), "too many nacks")
	`AJB_ASSERT_IMP(a_frame_play, clk, arst_n, emit_valid && emit_res.kind == KIND_FRAME, playing_q, "frame ok while not playing")

endmodule

// ===== test/jitter_buffer_checker.sv =====
// checker for audio_jitter_buffer_control: watches the config, input and result channels,
// predicts the result words of every accepted input word and compares them in order
// depends on ajb_pkg for widths and result codes
module jitter_buffer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [ajb_pkg::TD_W-1:0]            start_depth,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                req_type,
	input  logic [ajb_pkg::SEQ_W-1:0]           seq_num,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [ajb_pkg::KIND_W-1:0]          kind,
	input  logic [$clog2(ajb_pkg::SLOTS_DEF)-1:0] slot_index,
	input  logic [ajb_pkg::SEQ_W-1:0]           nack_seq,
	input  logic                                silence,
	input  logic [ajb_pkg::GAIN_W-1:0]          gain_start,
	input  logic [ajb_pkg::GAIN_W-1:0]          gain_end,
	input  logic                                last,
	output int                                  fail_count,
	output int                                  results_pending,
	output int                                  words_in,
	output int                                  results_out
);
	timeunit 1ns;
	timeprecision 1ps;

	import ajb_pkg::*;

	localparam int SLOTS     = SLOTS_DEF;
	localparam int MAX_NACKS = MAX_NACKS_DEF;
	localparam int SLOT_W    = $clog2(SLOTS);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [SEQ_W-1:0]  nack;
		logic              silence;
		logic [GAIN_W-1:0] g0;
		logic [GAIN_W-1:0] g1;
		logic              last;
	} buf_result_t;

	buf_result_t results_due[$];
	buf_result_t got, want;

	logic              slot_ok [SLOTS];
	logic [SEQ_W-1:0]  slot_seq [SLOTS];
	logic              playing, anchored, good_frame, concealed;
	logic [SEQ_W-1:0]  rd_ptr, wr_ptr;
	int                filled;
	logic [GAIN_W-1:0] fade;
	logic [TD_W-1:0]   depth_reg;

	int fails = 0;
	int pending_n = 0;
	int words_seen = 0;
	int results_seen = 0;

	assign fail_count      = fails;
	assign results_pending = pending_n;
	assign words_in        = words_seen;
	assign results_out     = results_seen;

	function automatic int seq_gap(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return int'($signed(d));
	endfunction

	function void add_due(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
			input logic [SEQ_W-1:0] nk, input logic sil, input logic [GAIN_W-1:0] g0,
			input logic [GAIN_W-1:0] g1, input logic lst);
		buf_result_t r;
		r = '{kind: k, slot: s, nack: nk, silence: sil, g0: g0, g1: g1, last: lst};
		results_due.push_back(r);
	endfunction

	task automatic fade_step(input logic [KIND_W-1:0] k);
		concealed = 1'b1;
		if (!good_frame || fade == '0) begin
			fade = '0;
			add_due(k, '0, '0, 1'b1, '0, '0, 1'b1);
		end else begin
			add_due(k, '0, '0, 1'b0, fade, fade - 1'b1, 1'b1);
			fade = fade - 1'b1;
		end
	endtask

	task automatic clear_model();
		for (int i = 0; i < SLOTS; i++) begin
			slot_ok[i]  = 1'b0;
			slot_seq[i] = '0;
		end
		playing    = 1'b0;
		anchored   = 1'b0;
		good_frame = 1'b0;
		concealed  = 1'b0;
		rd_ptr     = '0;
		wr_ptr     = '0;
		filled     = 0;
		fade       = FULL_GAIN;
		depth_reg  = TD_RESET;
		results_due.delete();
	endtask

	task automatic predict_buffer_results(input logic req, input logic [SEQ_W-1:0] seq);
		logic [SEQ_W-1:0]  miss;
		logic [SLOT_W-1:0] idx;
		logic [GAIN_W-1:0] g0;
		int                n;
		n = 0;
		if (req != REQ_GET) begin
			if (!anchored) begin
				anchored = 1'b1;
				playing  = 1'b0;
				rd_ptr   = seq;
				wr_ptr   = seq;
			end
			if ((playing && seq_gap(seq, rd_ptr) < 0) || seq_gap(seq, rd_ptr) >= SLOTS) begin
				add_due(KIND_DROP, '0, '0, 1'b0, '0, '0, 1'b1);
				return;
			end
			if (seq_gap(seq, wr_ptr) > 1) begin
				miss = wr_ptr + 1'b1;
				while (seq_gap(seq, miss) > 0) begin
					if (!(playing && seq_gap(miss, rd_ptr) < 0)) begin
						if (n >= MAX_NACKS)
							break;
						add_due(KIND_NACK, '0, miss, 1'b0, '0, '0, 1'b0);
						n++;
					end
					miss = miss + 1'b1;
				end
			end
			idx = SLOT_W'(seq % SLOTS);
			if (!slot_ok[idx])
				filled++;
			slot_ok[idx]  = 1'b1;
			slot_seq[idx] = seq;
			if (seq_gap(seq, wr_ptr) > 0)
				wr_ptr = seq;
			add_due(KIND_WRITE, idx, '0, 1'b0, '0, '0, 1'b1);
			return;
		end
		if (!playing) begin
			if (!anchored || filled < int'(depth_reg)) begin
				fade_step(KIND_PRE);
				return;
			end
			playing = 1'b1;
		end
		idx = SLOT_W'(rd_ptr % SLOTS);
		if (slot_ok[idx] && slot_seq[idx] == rd_ptr) begin
			g0 = (concealed && fade < FULL_GAIN) ? fade : FULL_GAIN;
			slot_ok[idx] = 1'b0;
			filled--;
			rd_ptr     = rd_ptr + 1'b1;
			good_frame = 1'b1;
			fade       = FULL_GAIN;
			concealed  = 1'b0;
			add_due(KIND_FRAME, idx, '0, 1'b0, g0, FULL_GAIN, 1'b1);
		end else if (filled == 0) begin
			playing  = 1'b0;
			anchored = 1'b0;
			fade_step(KIND_PRE);
		end else begin
			rd_ptr = rd_ptr + 1'b1;
			fade_step(KIND_CONC);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (out_valid && !out_stall) begin
				got = '{kind: kind, slot: slot_index, nack: nack_seq, silence: silence,
					g0: gain_start, g1: gain_end, last: last};
				results_seen++;
				if (results_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result word: kind %0d slot %0d nack %h last %b",
							got.kind, got.slot, got.nack, got.last);
				end else begin
					want = results_due.pop_front();
					if (got.kind !== want.kind || got.slot !== want.slot ||
							got.nack !== want.nack || got.silence !== want.silence ||
							got.g0 !== want.g0 || got.g1 !== want.g1 ||
							got.last !== want.last) begin
						fails++;
						if (fails <= 10)
							$display("result %0d mismatch (exp/got): kind %0d/%0d slot %0d/%0d",
								results_seen, want.kind, got.kind, want.slot, got.slot,
								" nack %h/%h silence %b/%b gain %0d-%0d/%0d-%0d last %b/%b",
								want.nack, got.nack, want.silence, got.silence,
								want.g0, want.g1, got.g0, got.g1, want.last, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				depth_reg = start_depth;
			if (in_valid && !in_stall) begin
				words_seen++;
				predict_buffer_results(req_type, seq_num);
			end
		end
		pending_n = results_due.size();
	end

endmodule

// ===== test/tb_top.sv =====
// top of the jitter buffer control testbench: clock, reset, config writes, put/get stimulus
// with random gaps and output stalls; checking is done by jitter_buffer_checker
// depends on ajb_pkg, audio_jitter_buffer_control and jitter_buffer_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ajb_pkg::*;

	localparam logic REQ_PUT = ~REQ_GET;
	localparam int   LIMIT   = 200000;
	localparam int   SETTLE  = 64;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [TD_W-1:0]                  start_depth;
	logic                             in_valid;
	logic                             in_stall;
	logic                             req_type;
	logic [SEQ_W-1:0]                 seq_num;
	logic                             out_valid;
	logic                             out_stall;
	logic [KIND_W-1:0]                kind;
	logic [$clog2(SLOTS_DEF)-1:0]     slot_index;
	logic [SEQ_W-1:0]                 nack_seq;
	logic                             silence;
	logic [GAIN_W-1:0]                gain_start;
	logic [GAIN_W-1:0]                gain_end;
	logic                             last;

	int fail_count;
	int results_pending;
	int words_in;
	int results_out;
	int cycles = 0;
	bit quiet;

	logic [SEQ_W-1:0] next_seq;
	logic [SEQ_W-1:0] last_put;
	logic [SEQ_W-1:0] skipped[$];

	audio_jitter_buffer_control u_dut (.*);

	jitter_buffer_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(0, 99) < 16);

	task automatic send_word(input logic req, input logic [SEQ_W-1:0] seq);
		while (!quiet && $urandom_range(0, 99) < 16) begin
			@(negedge clk) in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		seq_num  <= seq;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic get_frame();
		send_word(REQ_GET, SEQ_W'($urandom));
	endtask

	// only while nothing is in flight
	task automatic load_depth(input logic [TD_W-1:0] depth);
		@(negedge clk) in_valid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid   <= 1'b1;
		start_depth <= depth;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// run playback dry so the next put re-anchors at a new base
	task automatic drain_and_rebase(input logic [SEQ_W-1:0] base);
		load_depth('0);
		repeat (28) get_frame();
		next_seq = base;
		skipped.delete();
	endtask

	task automatic run_stream(input int count, input int put_pct);
		int               m;
		int               k;
		logic [SEQ_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) >= put_pct) begin
				get_frame();
				continue;
			end
			m = $urandom_range(0, 99);
			if (m < 68) begin
				s = next_seq;
				next_seq = next_seq + 1'b1;
			end else if (m < 78) begin
				k = $urandom_range(1, 11);
				for (int j = 0; j < k; j++)
					if (skipped.size() < 16)
						skipped.push_back(next_seq + SEQ_W'(j));
				s = next_seq + SEQ_W'(k);
				next_seq = s + 1'b1;
			end else if (m < 88 && skipped.size() > 0) begin
				k = $urandom_range(0, skipped.size() - 1);
				s = skipped[k];
				skipped.delete(k);
			end else if (m < 94) begin
				s = last_put;
			end else begin
				s = next_seq + SEQ_W'($urandom_range(0, 80)) - SEQ_W'(40);
			end
			last_put = s;
			send_word(REQ_PUT, s);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		start_depth = '0;
		in_valid    = 1'b0;
		req_type    = 1'b0;
		seq_num     = '0;
		out_stall   = 1'b0;
		quiet       = 1'b0;
		next_seq    = '0;
		last_put    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		load_depth(5'd2);
		get_frame();
		send_word(REQ_PUT, 16'hFFFE);
		send_word(REQ_PUT, 16'h0003);
		send_word(REQ_PUT, 16'hFFDE);
		send_word(REQ_PUT, 16'h0040);
		repeat (2) get_frame();
		send_word(REQ_PUT, 16'h0000);
		send_word(REQ_PUT, 16'hFFF0);
		repeat (4) get_frame();
		send_word(REQ_PUT, 16'h000E);
		send_word(REQ_PUT, 16'h0004);
		repeat (11) get_frame();
		send_word(REQ_PUT, 16'h001E);

		drain_and_rebase(SEQ_W'($urandom));
		load_depth(5'd31);
		run_stream(44, 85);
		load_depth(5'd0);
		run_stream(32, 50);
		drain_and_rebase(16'hFFE8);
		load_depth(TD_W'($urandom_range(1, 30)));
		quiet = 1'b1;
		run_stream(32, 50);
		quiet = 1'b0;
		load_depth(5'd1);
		run_stream(32, 45);
		load_depth(5'd5);
		run_stream(32, 55);

		@(negedge clk) in_valid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d put/get words and %0d result words, depths 0 to 31, seq wrap",
			words_in, results_out);
		if (fail_count == 0 && results_pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
